@@ src/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache: field widths,
// request codes and the control/result structs of the entry compare unit.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Default number of cache entries
    localparam int ENTRIES_DEF = 16;

    // Request and result field widths
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    // Capacity register reset value
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request type codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // Result returned by a get that misses; a put always returns zero
    localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;
    localparam logic signed [VALUE_W-1:0] PUT_VALUE  = 32'sd0;

    typedef logic [KEY_W-1:0]          t_key;
    typedef logic signed [VALUE_W-1:0] t_value;

    // Control into the entry compare unit
    typedef struct packed {
        logic ent_valid;   // entry under test holds data
        logic is_target;   // entry under test is the one being touched
        logic inc_all;     // fill: every valid entry ages by one
        logic vic_have;    // a victim candidate has already been seen
    } t_cmp_ctl;

    // Flags out of the entry compare unit
    typedef struct packed {
        logic key_match;   // valid entry with the requested key
        logic age_inc;     // entry moves one rank older
        logic age_older;   // entry is older than the current victim candidate
    } t_cmp_res;

endpackage

@@ src/lkv_if.sv @@
// ----------------------------------------------------------------------------
// lkv_if
// Valid/ready channels of the LRU key-value cache: the request channel and
// the response channel.
// ----------------------------------------------------------------------------
interface lkv_req_if;
    import lkv_pkg::*;

    logic   valid;
    logic   ready;
    logic   req_type;
    t_key   key;
    t_value value;

    modport source (output valid, req_type, key, value, input ready);
    modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic   valid;
    logic   ready;
    logic   hit;
    t_value read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

@@ src/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request (req_type get/put, key, value) under valid/ready;
//   o_rsp returns exactly one response per request (hit, read_value).
//   i_cfg_we / i_cfg_wdata write the capacity register (zero acts as one,
//   values above ENTRIES act as ENTRIES); write it only while idle.
// Timing:
//   A request walks the tag memory one entry per cycle through its single
//   read port: a scan pass (key match, free slot, oldest entry), a decide
//   cycle, a rank-update pass and a response cycle; a get miss skips the
//   update pass. One request is in flight at a time; ready is high only
//   while idle and out of reset, so a new request is accepted only once
//   the previous one has left the response cycle.
// Reset clears all valid bits, the fill count and the response register and
// sets capacity to 16; key, value and rank memories need no clearing.
// A stalled receiver holds the response; the next request is still accepted
// and its response waits in the response cycle until the register frees.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lkv_req_if.sink                   i_req,
    lkv_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_wdata
);
    import lkv_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int AGE_W = IDX_W;
    localparam int TAG_W = KEY_W + AGE_W;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    // request outcomes
    localparam logic [1:0] M_HIT   = 2'd0;
    localparam logic [1:0] M_MISS  = 2'd1;
    localparam logic [1:0] M_FILL  = 2'd2;
    localparam logic [1:0] M_EVICT = 2'd3;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_idx;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_filled;
    logic [CAP_W-1:0]   r_cap;

    logic               r_put;
    t_key               r_key;
    t_value             r_value;

    logic               r_found;
    logic [IDX_W-1:0]   r_found_slot;
    logic [AGE_W-1:0]   r_found_age;
    logic               r_free_have;
    logic [IDX_W-1:0]   r_free_slot;
    logic               r_vic_have;
    logic [IDX_W-1:0]   r_vic_slot;
    logic [AGE_W-1:0]   r_vic_age;

    logic [IDX_W-1:0]   r_target;
    logic [AGE_W-1:0]   r_thr;
    logic               r_inc_all;
    logic [1:0]         r_mode;

    logic               r_out_valid;
    logic               r_out_hit;
    t_value             r_out_value;

    logic [TAG_W-1:0]   tag_q;
    logic [TAG_W-1:0]   tag_wdata;
    logic               tag_we;
    logic [VALUE_W-1:0] val_q;
    logic               val_we;

    t_key               ent_key;
    logic [AGE_W-1:0]   ent_age;
    logic [AGE_W-1:0]   next_age;
    t_cmp_ctl           cmp_ctl;
    t_cmp_res           cmp_res;

    logic               pass_end;
    logic               req_acc;
    logic [CAP_W-1:0]   cap_eff;
    logic               room;
    logic [1:0]         d_mode;
    logic [IDX_W-1:0]   d_target;
    logic [AGE_W-1:0]   d_thr;

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && i_rst_n;
    assign pass_end    = (r_idx == CNT_W'(ENTRIES)) && r_rd_vld;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_value;

    // key and recency rank per entry
    lkv_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_rd_idx),
        .i_wdata (tag_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (tag_q)
    );

    // stored values
    lkv_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (d_target),
        .i_wdata (r_value),
        .i_raddr (r_target),
        .o_rdata (val_q)
    );

    assign ent_key = tag_q[TAG_W-1:AGE_W];
    assign ent_age = tag_q[AGE_W-1:0];

    always_comb begin
        cmp_ctl.ent_valid = r_valid[r_rd_idx];
        cmp_ctl.is_target = (r_rd_idx == r_target);
        cmp_ctl.inc_all   = r_inc_all;
        cmp_ctl.vic_have  = r_vic_have;
    end

    lkv_cmp_unit #(
        .AGE_W (AGE_W)
    ) u_cmp (
        .i_ctl      (cmp_ctl),
        .i_req_key  (r_key),
        .i_ent_key  (ent_key),
        .i_ent_age  (ent_age),
        .i_thr      (r_thr),
        .i_vic_age  (r_vic_age),
        .o_res      (cmp_res),
        .o_next_age (next_age)
    );

    // outcome of the scan pass
    always_comb begin
        cap_eff = (r_cap == '0) ? CAP_W'(1) : r_cap;
        room    = (CMP_W'(r_filled) < CMP_W'(cap_eff)) &&
                  (r_filled < CNT_W'(ENTRIES)) && r_free_have;
        if (r_found) begin
            d_mode   = M_HIT;
            d_target = r_found_slot;
            d_thr    = r_found_age;
        end else if (r_put != REQ_PUT) begin
            d_mode   = M_MISS;
            d_target = r_found_slot;
            d_thr    = r_found_age;
        end else if (room) begin
            d_mode   = M_FILL;
            d_target = r_free_slot;
            d_thr    = r_vic_age;
        end else begin
            d_mode   = M_EVICT;
            d_target = r_vic_slot;
            d_thr    = r_vic_age;
        end
    end

    // memory writes: value at decide, ranks during the update pass
    assign val_we    = (r_state == S_DECIDE) && (r_put == REQ_PUT) && (d_mode != M_MISS);
    assign tag_we    = (r_state == S_UPDATE) && r_rd_vld &&
                       (cmp_ctl.ent_valid || cmp_ctl.is_target);
    assign tag_wdata = {(cmp_ctl.is_target ? r_key : ent_key), next_age};

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (pass_end) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = (d_mode == M_MISS) ? S_RESP : S_UPDATE;
            end
            S_UPDATE: begin
                if (pass_end) n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_valid     <= '0;
            r_filled    <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_free_have <= 1'b0;
            r_vic_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            // response register: load when free, clear when taken
            if (r_state == S_RESP && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx       <= '0;
                    r_rd_vld    <= 1'b0;
                    r_found     <= 1'b0;
                    r_free_have <= 1'b0;
                    r_vic_have  <= 1'b0;
                end
                S_SCAN, S_UPDATE: begin
                    if (r_idx != CNT_W'(ENTRIES)) begin
                        r_idx    <= r_idx + CNT_W'(1);
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    // scan bookkeeping
                    if (r_state == S_SCAN && r_rd_vld) begin
                        if (cmp_res.key_match && !r_found) begin
                            r_found <= 1'b1;
                        end
                        if (!cmp_ctl.ent_valid && !r_free_have) begin
                            r_free_have <= 1'b1;
                        end
                        if (cmp_res.age_older) begin
                            r_vic_have <= 1'b1;
                        end
                    end
                    // a fill claims its slot when the update pass ends
                    if (r_state == S_UPDATE && pass_end && r_mode == M_FILL) begin
                        r_valid[r_target] <= 1'b1;
                        r_filled          <= r_filled + CNT_W'(1);
                    end
                end
                S_DECIDE: begin
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                end
                default: begin
                    r_idx <= '0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_put   <= i_req.req_type;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
        if (r_state == S_SCAN || r_state == S_UPDATE) begin
            if (r_idx != CNT_W'(ENTRIES)) begin
                r_rd_idx <= r_idx[IDX_W-1:0];
            end
        end
        if (r_state == S_SCAN && r_rd_vld) begin
            if (cmp_res.key_match && !r_found) begin
                r_found_slot <= r_rd_idx;
                r_found_age  <= ent_age;
            end
            if (!cmp_ctl.ent_valid && !r_free_have) begin
                r_free_slot <= r_rd_idx;
            end
            if (cmp_res.age_older) begin
                r_vic_slot <= r_rd_idx;
                r_vic_age  <= ent_age;
            end
        end
        if (r_state == S_DECIDE) begin
            r_target  <= d_target;
            r_thr     <= d_thr;
            r_inc_all <= (d_mode == M_FILL);
            r_mode    <= d_mode;
        end
        if (r_state == S_RESP && (!r_out_valid || o_rsp.ready)) begin
            r_out_hit <= (r_mode == M_HIT);
            if (r_put == REQ_PUT) begin
                r_out_value <= PUT_VALUE;
            end else if (r_mode == M_HIT) begin
                r_out_value <= val_q;
            end else begin
                r_out_value <= MISS_VALUE;
            end
        end
    end

    // fill count tracks the valid bits
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled == CNT_W'($countones(r_valid)))
        else $error("fill count differs from number of valid entries");

    // an accepted request starts a fresh scan from entry zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state == S_SCAN) && (r_idx == '0) && !i_req.ready)
        else $error("request accepted without starting a scan");

    // a response is loaded only after a request went through the sequencer
    a_resp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_RESP)
        else $error("response raised outside the response cycle");

endmodule

@@ src/lkv_ram.sv @@
// ----------------------------------------------------------------------------
// lkv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lkv_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// lkv_cmp_unit
// Shared entry compare unit: key match, victim age compare and the recency
// rank update for the one entry read from the tag memory each cycle.
// ----------------------------------------------------------------------------
module lkv_cmp_unit #(
    parameter int AGE_W = 4
) (
    input  lkv_pkg::t_cmp_ctl i_ctl,
    input  lkv_pkg::t_key     i_req_key,
    input  lkv_pkg::t_key     i_ent_key,
    input  logic [AGE_W-1:0]  i_ent_age,
    input  logic [AGE_W-1:0]  i_thr,
    input  logic [AGE_W-1:0]  i_vic_age,
    output lkv_pkg::t_cmp_res o_res,
    output logic [AGE_W-1:0]  o_next_age
);
    import lkv_pkg::*;

    // compares against the entry under test
    always_comb begin
        o_res.key_match = i_ctl.ent_valid && (i_ent_key == i_req_key);
        o_res.age_inc   = i_ctl.ent_valid && !i_ctl.is_target &&
                          (i_ctl.inc_all || (i_ent_age < i_thr));
        o_res.age_older = i_ctl.ent_valid &&
                          (!i_ctl.vic_have || (i_ent_age > i_vic_age));
    end

    // touched entry becomes most recent, younger ones step back one rank (on a fill, every valid entry)
    always_comb begin
        if (i_ctl.is_target) begin
            o_next_age = '0;
        end else if (o_res.age_inc) begin
            o_next_age = i_ent_age + AGE_W'(1);
        end else begin
            o_next_age = i_ent_age;
        end
    end

endmodule
